[hw/rtl/igrs_pkg.sv]
// Shared types, constants and float helpers for the int8 row-scaled GEMV block.
package igrs_pkg;

  localparam int MAX_ROWS  = 4096;
  localparam int ROW_W     = 12;
  localparam int EXP_W     = 11;
  localparam int IN_W      = 104;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN  = 1'b1;

  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] FP_INF      = 32'h7F80_0000;

  typedef enum logic [1:0] {
    OP_MAC,
    OP_SCALE,
    OP_BIAS
  } igrs_op_t;

  typedef struct packed {
    logic     capture;
    logic     issue;
    igrs_op_t op;
    logic     sum_load;
    logic     emit;
  } igrs_cmd_t;

  typedef struct packed {
    logic done;
    logic last_row;
  } igrs_sts_t;

  typedef struct packed {
    logic                    sgn;
    logic signed [EXP_W-1:0] exp;
    logic [23:0]             man;
    logic                    zero;
    logic                    inf;
    logic                    nan;
  } igrs_opnd_t;

  function automatic igrs_opnd_t fp_unpack(input logic [31:0] f);
    igrs_opnd_t o;
    o.sgn  = f[31];
    o.zero = (f[30:23] == 8'h00) && (f[22:0] == 23'd0);
    o.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    o.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    o.man  = {(f[30:23] != 8'h00), f[22:0]};
    if (f[30:23] == 8'h00) begin
      o.exp = -11'sd126;
    end else begin
      o.exp = $signed({3'b000, f[30:23]}) - 11'sd127;
    end
    return o;
  endfunction

  function automatic igrs_opnd_t int8_opnd(input logic [7:0] w);
    igrs_opnd_t o;
    logic [7:0] mag;
    mag    = w[7] ? 8'(~w + 8'd1) : w;
    o.sgn  = w[7];
    o.exp  = 11'sd23;
    o.man  = {16'd0, mag};
    o.zero = (w == 8'd0);
    o.inf  = 1'b0;
    o.nan  = 1'b0;
    return o;
  endfunction

  function automatic logic [4:0] clz24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] clz16(input logic [15:0] m);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (m[i]) n = 5'(15 - i);
    end
    return n;
  endfunction

  function automatic igrs_opnd_t opnd_norm(input igrs_opnd_t o);
    igrs_opnd_t r;
    logic [4:0] lz;
    lz    = clz24(o.man);
    r     = o;
    r.man = o.man << lz;
    r.exp = o.exp - $signed({6'd0, lz});
    return r;
  endfunction

endpackage

[hw/rtl/int8_gemv_row_scaled.sv]
// Top level: int8 x binary32 row dot products with per-row scale and bias.
// Sequencing: a non-final element occupies the block for one pass of the single
//   8-stage fused multiply-add. The final element of a row also takes a scale pass
//   and, with bias enabled, a bias pass through the same unit before its result.
// Throughput: one element at a time; the next waits until the last is finished.
// Reset (rst_n low, synchronous): row sum +0, row index 0, scaling on, bias off.
module int8_gemv_row_scaled import igrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [0:0]           cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // weight, activation, row_scale, row_bias
  input  logic                 in_tlast,   // last_in_row
  input  logic                 in_tuser,   // last_in_matrix
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // row_result, row_index, zero pad
  output logic                 out_tlast   // matrix_done
);

  logic             scale_en_r, bias_en_r;
  igrs_cmd_t        cmd;
  igrs_sts_t        sts;
  logic [31:0]      row_result;
  logic [ROW_W-1:0] row_index;
  logic             matrix_done;

  // Configuration registers; the one-bit index selects scale enable or bias enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_en_r <= 1'b1;
      bias_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_EN: scale_en_r <= cfg_wdata[0];
        REG_BIAS_EN:  bias_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept one element, hold off further transfers until its
  // multiply-add (and, at row end, scale, bias if enabled, and the result emit) has drained.
  igrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .bias_en   (bias_en_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: FMA unit, row sum, row counter and the output register, which
  // parts the two sides so a waiting result does not block new elements.
  igrs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .weight         (in_tdata[7:0]),
    .activation     (in_tdata[39:8]),
    .row_scale      (in_tdata[71:40]),
    .row_bias       (in_tdata[103:72]),
    .last_in_row    (in_tlast),
    .last_in_matrix (in_tuser),
    .scale_en       (scale_en_r),
    .cmd            (cmd),
    .sts            (sts),
    .row_result     (row_result),
    .row_index      (row_index),
    .matrix_done    (matrix_done)
  );

  assign out_tdata = {4'd0, row_index, row_result};
  assign out_tlast = matrix_done;

`ifndef SYNTHESIS
  // One element in flight at a time.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input transfer accepted while an element is in flight");

  // The FMA only finishes work that the sequencer started.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !in_tready)
    else $error("FMA result while the sequencer is idle");

  // A result is latched only on an emit command.
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && !cmd.emit) |=> !out_tvalid)
    else $error("result raised without an emit");
`endif

endmodule

[hw/rtl/igrs_fma.sv]
// Eight-stage binary32 fused multiply-add, a*b+c rounded once to nearest even.
module igrs_fma import igrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  igrs_opnd_t  a,
  input  igrs_opnd_t  b,
  input  logic [31:0] c_bits,
  output logic        out_valid,
  output logic [31:0] out_res
);

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  // stage 1: unpack and normalise operands
  igrs_opnd_t  a1_r, b1_r, c1_r;
  logic [31:0] cb1_r;

  always_ff @(posedge clk) begin
    if (in_valid) begin
      a1_r  <= opnd_norm(a);
      b1_r  <= opnd_norm(b);
      c1_r  <= opnd_norm(fp_unpack(c_bits));
      cb1_r <= c_bits;
    end
  end

  // stage 2: multiply, special operands
  logic                    sp1, nan1, spec1;
  logic [31:0]             sres1;
  logic signed [EXP_W-1:0] ep1, sh1;

  always_comb begin
    sp1  = a1_r.sgn ^ b1_r.sgn;
    ep1  = a1_r.exp + b1_r.exp;
    sh1  = 11'sd28 + ep1 - c1_r.exp;
    nan1 = a1_r.nan || b1_r.nan || c1_r.nan ||
           (a1_r.inf && b1_r.zero) || (a1_r.zero && b1_r.inf) ||
           ((a1_r.inf || b1_r.inf) && c1_r.inf && (sp1 != c1_r.sgn));
    spec1 = 1'b1;
    sres1 = FP_QNAN;
    if (nan1) begin
      sres1 = FP_QNAN;
    end else if (a1_r.inf || b1_r.inf) begin
      sres1 = {sp1, FP_INF[30:0]};
    end else if (c1_r.inf) begin
      sres1 = {c1_r.sgn, FP_INF[30:0]};
    end else if (a1_r.zero || b1_r.zero) begin
      sres1 = c1_r.zero ? {sp1 & c1_r.sgn, 31'd0} : cb1_r;
    end else begin
      spec1 = 1'b0;
    end
  end

  logic [47:0]             mp2_r;
  logic signed [EXP_W-1:0] ep2_r, sh2_r, ec2_r;
  logic [23:0]             mc2_r;
  logic                    sp2_r, sc2_r, cz2_r, spec2_r;
  logic [31:0]             sres2_r;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      mp2_r   <= a1_r.man * b1_r.man;
      ep2_r   <= ep1;
      sh2_r   <= sh1;
      ec2_r   <= c1_r.exp;
      mc2_r   <= c1_r.man;
      sp2_r   <= sp1;
      sc2_r   <= c1_r.sgn;
      cz2_r   <= c1_r.zero;
      spec2_r <= spec1;
      sres2_r <= sres1;
    end
  end

  // stage 3: align addend against product in a 77-bit window
  logic [76:0]             ps2, ax2, pa2, aa2;
  logic [6:0]              s2;
  logic signed [EXP_W-1:0] eb2;

  always_comb begin
    ps2 = {27'd0, mp2_r, 2'b00};
    ax2 = {mc2_r, 53'd0};
    s2  = (sh2_r > 11'sd77) ? 7'd77 : sh2_r[6:0];
    pa2 = ps2;
    aa2 = 77'd0;
    eb2 = ep2_r - 11'sd48;
    if (cz2_r) begin
      aa2 = 77'd0;
    end else if (sh2_r < 11'sd0) begin
      // addend dominates: product collapses into the sticky bit
      aa2 = ax2;
      pa2 = 77'd1;
      eb2 = ec2_r - 11'sd76;
    end else begin
      aa2    = ax2 >> s2;
      aa2[0] = aa2[0] | (|(ax2 & ~({77{1'b1}} << s2)));
    end
  end

  logic [76:0]             p3_r, a3_r;
  logic signed [EXP_W-1:0] eb3_r;
  logic                    sp3_r, sc3_r, spec3_r;
  logic [31:0]             sres3_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      p3_r    <= pa2;
      a3_r    <= aa2;
      eb3_r   <= eb2;
      sp3_r   <= sp2_r;
      sc3_r   <= sc2_r;
      spec3_r <= spec2_r;
      sres3_r <= sres2_r;
    end
  end

  // stage 4: add or subtract magnitudes
  logic [77:0] sum3, d13, d23, s3;
  logic        sg3;

  always_comb begin
    sum3 = {1'b0, p3_r} + {1'b0, a3_r};
    d13  = {1'b0, p3_r} - {1'b0, a3_r};
    d23  = {1'b0, a3_r} - {1'b0, p3_r};
    if (sp3_r == sc3_r) begin
      s3 = sum3; sg3 = sp3_r;
    end else if (d13[77]) begin
      s3 = d23; sg3 = sc3_r;
    end else begin
      s3 = d13; sg3 = sp3_r;
    end
  end

  logic [77:0]             s4_r;
  logic                    sg4_r, z4_r, spec4_r;
  logic signed [EXP_W-1:0] eb4_r;
  logic [31:0]             sres4_r;

  always_ff @(posedge clk) begin
    if (v3_r) begin
      s4_r    <= s3;
      sg4_r   <= sg3;
      z4_r    <= (s3 == 78'd0);
      eb4_r   <= eb3_r;
      spec4_r <= spec3_r;
      sres4_r <= sres3_r;
    end
  end

  // stage 5: coarse normalise by 16-bit groups
  logic [79:0] x4;
  logic [2:0]  g4;

  always_comb begin
    x4 = {s4_r, 2'b00};
    if (x4[79:64] != 16'd0) begin
      g4 = 3'd0;
    end else if (x4[63:48] != 16'd0) begin
      g4 = 3'd1;
    end else if (x4[47:32] != 16'd0) begin
      g4 = 3'd2;
    end else if (x4[31:16] != 16'd0) begin
      g4 = 3'd3;
    end else begin
      g4 = 3'd4;
    end
  end

  logic [79:0]             x5_r;
  logic [6:0]              lz5_r;
  logic                    sg5_r, z5_r, spec5_r;
  logic signed [EXP_W-1:0] eb5_r;
  logic [31:0]             sres5_r;

  always_ff @(posedge clk) begin
    if (v4_r) begin
      x5_r    <= x4 << {g4, 4'b0000};
      lz5_r   <= {g4, 4'b0000};
      sg5_r   <= sg4_r;
      z5_r    <= z4_r;
      eb5_r   <= eb4_r;
      spec5_r <= spec4_r;
      sres5_r <= sres4_r;
    end
  end

  // stage 6: fine normalise, biased exponent
  logic [4:0] f5;
  logic [6:0] lz5;

  always_comb begin
    f5  = clz16(x5_r[79:64]);
    lz5 = lz5_r + {2'b00, f5};
  end

  logic [79:0]             x6_r;
  logic signed [EXP_W-1:0] e6_r;
  logic                    sg6_r, z6_r, spec6_r;
  logic [31:0]             sres6_r;

  always_ff @(posedge clk) begin
    if (v5_r) begin
      x6_r    <= x5_r << f5;
      e6_r    <= eb5_r + 11'sd204 - $signed({4'd0, lz5});
      sg6_r   <= sg5_r;
      z6_r    <= z5_r;
      spec6_r <= spec5_r;
      sres6_r <= sres5_r;
    end
  end

  // stage 7: subnormal right shift
  logic signed [EXP_W-1:0] dn6;
  logic [4:0]              ds6;
  logic [79:0]             n6;
  logic [7:0]              base6;

  always_comb begin
    dn6   = 11'sd1 - e6_r;
    ds6   = (dn6 > 11'sd26) ? 5'd26 : dn6[4:0];
    n6    = x6_r;
    base6 = 8'd0;
    if (e6_r < 11'sd1) begin
      n6    = x6_r >> ds6;
      n6[0] = n6[0] | (|(x6_r & ~({80{1'b1}} << ds6)));
    end else begin
      base6 = 8'(e6_r - 11'sd1);
    end
  end

  logic [79:0] n7_r;
  logic [7:0]  base7_r;
  logic        ovf7_r, sg7_r, z7_r, spec7_r;
  logic [31:0] sres7_r;

  always_ff @(posedge clk) begin
    if (v6_r) begin
      n7_r    <= n6;
      base7_r <= base6;
      ovf7_r  <= (e6_r >= 11'sd255);
      sg7_r   <= sg6_r;
      z7_r    <= z6_r;
      spec7_r <= spec6_r;
      sres7_r <= sres6_r;
    end
  end

  // stage 8: round to nearest even and pack
  logic [23:0] man7;
  logic        rup7;
  logic [31:0] mag7, res7;

  always_comb begin
    man7 = n7_r[79:56];
    rup7 = n7_r[55] & ((|n7_r[54:0]) | man7[0]);
    mag7 = {1'b0, base7_r, 23'd0} + {8'd0, man7} + {31'd0, rup7};
    if (spec7_r) begin
      res7 = sres7_r;
    end else if (z7_r) begin
      res7 = 32'd0;
    end else if (ovf7_r) begin
      res7 = {sg7_r, FP_INF[30:0]};
    end else begin
      res7 = {sg7_r, mag7[30:0]};
    end
  end

  logic [31:0] res8_r;

  always_ff @(posedge clk) begin
    if (v7_r) begin
      res8_r <= res7;
    end
  end

  assign out_valid = v8_r;
  assign out_res   = res8_r;

endmodule

[hw/rtl/igrs_dp.sv]
// Datapath: item capture, FMA operand selection, row sum, row counter, result register.
module igrs_dp import igrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        weight,
  input  logic [31:0]       activation,
  input  logic [31:0]       row_scale,
  input  logic [31:0]       row_bias,
  input  logic              last_in_row,
  input  logic              last_in_matrix,
  input  logic              scale_en,
  input  igrs_cmd_t         cmd,
  output igrs_sts_t         sts,
  output logic [31:0]       row_result,
  output logic [ROW_W-1:0]  row_index,
  output logic              matrix_done
);

  logic [31:0]      scl_r, bias_r;
  logic             lrow_r, lmat_r;
  logic [31:0]      row_sum_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic [31:0]      res_o_r;
  logic [ROW_W-1:0] idx_o_r;
  logic             mat_o_r;

  igrs_opnd_t  op_a, op_b;
  logic [31:0] op_c;
  logic        fma_done;
  logic [31:0] fma_res;

  always_comb begin
    case (cmd.op)
      OP_SCALE: begin
        op_a = fp_unpack(fma_res);
        op_b = fp_unpack(scale_en ? scl_r : FP_ONE);
        op_c = FP_NEG_ZERO;
      end
      OP_BIAS: begin
        op_a = fp_unpack(fma_res);
        op_b = fp_unpack(FP_ONE);
        op_c = bias_r;
      end
      default: begin
        op_a = int8_opnd(weight);
        op_b = fp_unpack(activation);
        op_c = row_sum_r;
      end
    endcase
  end

  igrs_fma u_fma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.issue),
    .a         (op_a),
    .b         (op_b),
    .c_bits    (op_c),
    .out_valid (fma_done),
    .out_res   (fma_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scl_r  <= row_scale;
      bias_r <= row_bias;
      lrow_r <= last_in_row;
      lmat_r <= last_in_matrix;
    end
    if (cmd.emit) begin
      res_o_r <= fma_res;
      idx_o_r <= row_cnt_r;
      mat_o_r <= lmat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r <= 32'd0;
      row_cnt_r <= '0;
    end else begin
      if (cmd.sum_load) begin
        row_sum_r <= lrow_r ? 32'd0 : fma_res;
      end
      if (cmd.emit) begin
        if (lmat_r || (row_cnt_r == ROW_W'(MAX_ROWS - 1))) begin
          row_cnt_r <= '0;
        end else begin
          row_cnt_r <= row_cnt_r + 1'b1;
        end
      end
    end
  end

  assign sts.done     = fma_done;
  assign sts.last_row = lrow_r;
  assign row_result   = res_o_r;
  assign row_index    = idx_o_r;
  assign matrix_done  = mat_o_r;

endmodule

[hw/rtl/igrs_ctrl.sv]
// Controller: sequences multiply-add, scale and bias passes and the result transfer.
module igrs_ctrl import igrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      bias_en,
  input  igrs_sts_t sts,
  output igrs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SCALE,
    S_BIAS,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{capture: 1'b0, issue: 1'b0, op: OP_MAC, sum_load: 1'b0, emit: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.issue   = 1'b1;
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        if (sts.done) begin
          cmd.sum_load = 1'b1;
          if (sts.last_row) begin
            cmd.issue = 1'b1;
            cmd.op    = OP_SCALE;
            state_nxt = S_SCALE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCALE: begin
        cmd.op = OP_SCALE;
        if (sts.done) begin
          if (bias_en) begin
            cmd.issue = 1'b1;
            cmd.op    = OP_BIAS;
            state_nxt = S_BIAS;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_BIAS: begin
        cmd.op = OP_BIAS;
        if (sts.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
